// ----- design/srcp_pkg.sv -----
// shared constants, codes, pattern table and types of the command line parser
package srcp_pkg;

    localparam int NUM_VALUES_DEF = 15;
    localparam int SLOT_W         = 4;
    localparam int CHAR_W         = 8;
    localparam int WORD_W         = 32;
    localparam int CMD_W          = 4;
    localparam int DEV_W          = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_UNKNOWN  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_CONNMODE = 4'd1;
    localparam logic [CMD_W-1:0] CMD_PROTOCOL = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SET      = 4'd3;
    localparam logic [CMD_W-1:0] CMD_GET      = 4'd4;
    localparam logic [CMD_W-1:0] CMD_WAIT     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_INIT     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_TERM     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_GO       = 4'd8;

    // device codes
    localparam logic [DEV_W-1:0] DEV_NONE  = 3'd0;
    localparam logic [DEV_W-1:0] DEV_POWER = 3'd1;
    localparam logic [DEV_W-1:0] DEV_FB    = 3'd2;
    localparam logic [DEV_W-1:0] DEV_GA    = 3'd3;
    localparam logic [DEV_W-1:0] DEV_GL    = 3'd4;
    localparam logic [DEV_W-1:0] DEV_SM    = 3'd5;
    localparam logic [DEV_W-1:0] DEV_CV    = 3'd6;

    // prefix patterns, the info pattern sits behind the connection mode text
    localparam int NUM_PAT  = 9;
    localparam int PAT_INFO = 8;
    localparam int PAT_OFF [NUM_PAT] = '{0, 0, 0, 0, 0, 0, 0, 0, 24};
    localparam int PAT_LEN [NUM_PAT] = '{23, 17, 3, 3, 4, 4, 4, 2, 4};

    function automatic logic [CHAR_W-1:0] pat_byte(input int i, input logic [5:0] j);
        logic [8*23-1:0] s;
        int              n;
        s = '0;
        n = 1;
        case (i)
            0: begin s = "SET CONNECTIONMODE SRCP"; n = 23; end
            1: begin s = "SET PROTOCOL SRCP";       n = 17; end
            2: begin s = "SET";                     n = 3;  end
            3: begin s = "GET";                     n = 3;  end
            4: begin s = "WAIT";                    n = 4;  end
            5: begin s = "INIT";                    n = 4;  end
            6: begin s = "TERM";                    n = 4;  end
            7: begin s = "GO";                      n = 2;  end
            8: begin s = "INFO";                    n = 4;  end
            default: begin s = '0; n = 1; end
        endcase
        return s[8*(n-1-int'(j)) +: 8];
    endfunction

    // access bundle of the value store
    typedef struct packed {
        logic              clr;
        logic              we;
        logic [SLOT_W-1:0] wa;
        logic [WORD_W-1:0] wd;
        logic              re;
        logic [SLOT_W-1:0] ra;
    } t_store_req;

endpackage

// ----- design/srcp_ifs.sv -----
// handshake interfaces for the character and result channels
interface srcp_in_if;
    logic                        valid;
    logic                        ready;
    logic [srcp_pkg::CHAR_W-1:0] char_code;
    logic                        line_end;
    modport source (output valid, char_code, line_end, input ready);
    modport sink (input valid, char_code, line_end, output ready);
endinterface

interface srcp_out_if;
    logic                               valid;
    logic                               ready;
    logic [srcp_pkg::CMD_W-1:0]         command_code;
    logic [srcp_pkg::DEV_W-1:0]         device_code;
    logic signed [srcp_pkg::WORD_W-1:0] bus_number;
    logic signed [srcp_pkg::WORD_W-1:0] address;
    logic [srcp_pkg::SLOT_W-1:0]        value_index;
    logic signed [srcp_pkg::WORD_W-1:0] value_word;
    logic                               last;
    modport source (output valid, command_code, device_code, bus_number, address,
                    value_index, value_word, last, input ready);
    modport sink (input valid, command_code, device_code, bus_number, address,
                  value_index, value_word, last, output ready);
endinterface

// ----- design/srcp_value_store.sv -----
// value store: one write and one registered read port, entries read zero until written
module srcp_value_store #(
    parameter int NUM_VALUES = srcp_pkg::NUM_VALUES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srcp_pkg::t_store_req        i_req,
    output logic [srcp_pkg::WORD_W-1:0] o_rd
);
    localparam int AW = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;

    logic [srcp_pkg::WORD_W-1:0] r_mem [NUM_VALUES];
    logic [NUM_VALUES-1:0]       r_vld;
    logic [srcp_pkg::WORD_W-1:0] r_rd;
    logic                        r_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.wa[AW-1:0]] <= 1'b1;
        end
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (i_req.re) begin
            r_rv <= r_vld[i_req.ra[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wa[AW-1:0]] <= i_req.wd;
        end
        if (i_req.re) begin
            r_rd <= r_mem[i_req.ra[AW-1:0]];
        end
    end

    assign o_rd = r_rv ? r_rd : '0;

endmodule

// ----- design/srcp_command_parser.sv -----
// command line parser: prefix classification, set/get scanning and result emission
//
//  channel   | dir | payload                                             | taken when
//  i_line    | in  | char_code, line_end                                 | valid & ready
//  o_result  | out | command_code, device_code, bus_number, address,     | valid & ready
//            |     | value_index, value_word, last                       |
//
// a character is taken whenever valid meets ready while a line is open; the
// final character moves to a state that closes the last token and classifies
// the line; the NUM_VALUES results then leave one by one, each read through the
// registered store port before the next read, and input waits until all are read
// synchronous active-low reset; the value store is emptied through its valid
// bits at reset and after each line, with no clearing pass
// a stalled result holds in the output register while the next read waits
module srcp_command_parser #(
    parameter int NUM_VALUES = srcp_pkg::NUM_VALUES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srcp_in_if.sink     i_line,
    srcp_out_if.source  o_result
);
    localparam int NF_STARTED = 0;
    localparam int NF_NEG     = 1;
    localparam int NF_DIGIT   = 2;

    typedef enum logic [2:0] {
        PH_SKIP0, PH_BUS, PH_DEV, PH_ADDR, PH_SMDEV, PH_VAL, PH_DONE
    } t_phase;

    // on/off matcher for the word after the device
    typedef enum logic [2:0] {
        ON_IDLE, ON_WAIT, ON_O, ON_HIT, ON_MISS
    } t_on;

    typedef enum logic [1:0] {
        ST_RUN, ST_FIN, ST_EMIT
    } t_ctl;

    typedef struct packed {
        t_phase                          ph;
        logic [39:0]                     tok;
        logic [2:0]                      tlen;
        logic [srcp_pkg::WORD_W-1:0]     acc;
        logic [2:0]                      nf;
        logic [srcp_pkg::SLOT_W-1:0]     slot;
        logic [srcp_pkg::WORD_W-1:0]     bus;
        logic [srcp_pkg::WORD_W-1:0]     addr;
        logic [srcp_pkg::DEV_W-1:0]      dev;
    } t_scan;

    typedef struct packed {
        t_scan                       s;
        logic                        cons;
        logic                        we;
        logic [srcp_pkg::SLOT_W-1:0] wa;
        logic [srcp_pkg::WORD_W-1:0] wd;
        logic                        arm;
    } t_step;

    localparam t_scan SCAN_INIT = '0;

    function automatic logic f_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] f_up(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    // token bytes are stored first character in the low byte
    function automatic logic [srcp_pkg::DEV_W-1:0] f_token_device(input logic [39:0] tok,
                                                                  input logic [2:0] tlen);
        logic [srcp_pkg::DEV_W-1:0] d;
        d = srcp_pkg::DEV_NONE;
        if (tlen >= 3'd5 && tok == "REWOP")              d = srcp_pkg::DEV_POWER;
        else if (tlen >= 3'd2 && tok[15:0] == "BF")      d = srcp_pkg::DEV_FB;
        else if (tlen >= 3'd2 && tok[15:0] == "AG")      d = srcp_pkg::DEV_GA;
        else if (tlen >= 3'd2 && tok[15:0] == "LG")      d = srcp_pkg::DEV_GL;
        else if (tlen >= 3'd2 && tok[15:0] == "MS")      d = srcp_pkg::DEV_SM;
        else if (tlen >= 3'd2 && tok[15:0] == "VC")      d = srcp_pkg::DEV_CV;
        return d;
    endfunction

    function automatic t_scan f_enter(input t_scan s, input t_phase ph);
        t_scan r;
        r      = s;
        r.ph   = ph;
        r.nf   = '0;
        r.acc  = '0;
        r.tok  = '0;
        r.tlen = '0;
        return r;
    endfunction

    function automatic t_step f_end_word(input t_scan s);
        t_step                      r;
        logic [srcp_pkg::DEV_W-1:0] d;
        r      = '0;
        r.s    = s;
        r.cons = 1'b1;
        d      = f_token_device(s.tok, s.tlen);
        case (s.ph)
            PH_SKIP0: r.s = f_enter(s, PH_BUS);
            PH_DEV: begin
                r.s.dev = d;
                r.arm   = 1'b1;
                r.s     = f_enter(r.s, PH_ADDR);
            end
            default: begin
                // sm target device goes to slot zero
                r.we     = 1'b1;
                r.wa     = '0;
                r.wd     = {{(srcp_pkg::WORD_W-srcp_pkg::DEV_W){1'b0}}, d};
                r.s.slot = 4'd1;
                r.s      = f_enter(r.s, PH_VAL);
            end
        endcase
        return r;
    endfunction

    function automatic t_step f_end_number(input t_scan s);
        t_step                       r;
        logic [srcp_pkg::WORD_W-1:0] v;
        logic [srcp_pkg::SLOT_W-1:0] lim;
        r   = '0;
        r.s = s;
        // saturate to the signed 32-bit range
        if (s.nf[NF_NEG]) v = (s.acc >= 32'h8000_0000) ? 32'h8000_0000 : 32'd0 - s.acc;
        else              v = (s.acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : s.acc;
        lim = (s.dev == srcp_pkg::DEV_SM) ? 4'd3 : srcp_pkg::SLOT_W'(NUM_VALUES);
        case (s.ph)
            PH_BUS: begin
                r.s.bus = v;
                r.s     = f_enter(r.s, PH_DEV);
            end
            PH_ADDR: begin
                r.s.addr = v;
                if (s.dev == srcp_pkg::DEV_POWER)   r.s = f_enter(r.s, PH_DONE);
                else if (s.dev == srcp_pkg::DEV_SM) r.s = f_enter(r.s, PH_SMDEV);
                else begin
                    r.s.slot = '0;
                    r.s      = f_enter(r.s, PH_VAL);
                end
            end
            default: begin
                if (s.slot < lim) begin
                    r.we = 1'b1;
                    r.wa = s.slot;
                    r.wd = v;
                end
                r.s.slot = s.slot + 4'd1;
                r.s      = f_enter(r.s, (s.slot + 4'd1 >= lim) ? PH_DONE : PH_VAL);
            end
        endcase
        return r;
    endfunction

    // one pass of the scanner over a character; cons low asks for a second pass
    function automatic t_step f_scan(input t_scan s, input logic [7:0] c);
        t_step       r;
        logic [35:0] m;
        logic        dig;
        r      = '0;
        r.s    = s;
        r.cons = 1'b1;
        m      = '0;
        dig    = (c >= "0" && c <= "9");
        if (s.ph == PH_DONE) begin
            r.cons = 1'b1;
        end else if (s.ph == PH_SKIP0 || s.ph == PH_DEV || s.ph == PH_SMDEV) begin
            if (!s.nf[NF_STARTED] && f_ws(c)) begin
                r.cons = 1'b1;
            end else if (s.nf[NF_STARTED] && f_ws(c)) begin
                r = f_end_word(s);
            end else begin
                r.s.nf[NF_STARTED] = 1'b1;
                if (s.tlen < 3'd5) begin
                    r.s.tok[8*s.tlen +: 8] = f_up(c);
                    r.s.tlen               = s.tlen + 3'd1;
                end
            end
        end else if (dig) begin
            m = {4'b0, s.acc} * 36'd10 + {32'b0, c[3:0]};
            r.s.acc          = (m > 36'h0_8000_0000) ? 32'h8000_0000 : m[31:0];
            r.s.nf[NF_STARTED] = 1'b1;
            r.s.nf[NF_DIGIT]   = 1'b1;
        end else if (!s.nf[NF_STARTED]) begin
            if (f_ws(c)) begin
                r.cons = 1'b1;
            end else if (c == "+" || c == "-") begin
                r.s.nf             = '0;
                r.s.nf[NF_STARTED] = 1'b1;
                r.s.nf[NF_NEG]     = (c == "-");
            end else begin
                r.s = f_enter(s, PH_DONE);
            end
        end else if (s.nf[NF_DIGIT]) begin
            r      = f_end_number(s);
            r.cons = 1'b0;
        end else begin
            r.s = f_enter(s, PH_DONE);
        end
        return r;
    endfunction

    function automatic logic f_matched(input logic [8:0] pm, input logic [5:0] pos, input int i);
        return pm[i] && (int'(pos) >= srcp_pkg::PAT_OFF[i] + srcp_pkg::PAT_LEN[i]);
    endfunction

    // line state
    t_scan                        r_s, n_s;
    logic [5:0]                   r_pos, n_pos;
    logic [8:0]                   r_pm, n_pm;
    t_on                          r_on, n_on;
    logic                         r_ended, n_ended;
    t_ctl                         r_ctl, n_ctl;
    logic [srcp_pkg::CMD_W-1:0]   r_cmd, n_cmd;
    logic                         r_info, n_info;
    logic                         r_ond, n_ond;
    // emission
    logic [srcp_pkg::SLOT_W-1:0]  r_k, n_k;
    logic                         r_pend, n_pend;
    logic [srcp_pkg::SLOT_W-1:0]  r_pk, n_pk;
    // output register
    logic                         r_ovalid, n_ovalid;
    logic [srcp_pkg::CMD_W-1:0]   r_ocmd, n_ocmd;
    logic [srcp_pkg::DEV_W-1:0]   r_odev, n_odev;
    logic [srcp_pkg::WORD_W-1:0]  r_obus, n_obus;
    logic [srcp_pkg::WORD_W-1:0]  r_oaddr, n_oaddr;
    logic [srcp_pkg::SLOT_W-1:0]  r_oidx, n_oidx;
    logic [srcp_pkg::WORD_W-1:0]  r_oval, n_oval;
    logic                         r_olast, n_olast;

    srcp_pkg::t_store_req         st_req;
    logic [srcp_pkg::WORD_W-1:0]  st_rd;
    t_step                        step1, step2, fin;
    logic                         in_acc;
    logic [7:0]                   c_in;
    logic [7:0]                   u_in;
    logic                         setget;

    assign in_acc = i_line.valid && i_line.ready;
    assign c_in   = i_line.char_code;
    assign u_in   = f_up(c_in);
    assign setget = (r_cmd == srcp_pkg::CMD_SET) || (r_cmd == srcp_pkg::CMD_GET);

    always_comb begin
        n_s      = r_s;
        n_pos    = r_pos;
        n_pm     = r_pm;
        n_on     = r_on;
        n_ended  = r_ended;
        n_ctl    = r_ctl;
        n_cmd    = r_cmd;
        n_info   = r_info;
        n_ond    = r_ond;
        n_k      = r_k;
        n_pend   = r_pend;
        n_pk     = r_pk;
        n_ovalid = r_ovalid && !o_result.ready;
        n_ocmd   = r_ocmd;
        n_odev   = r_odev;
        n_obus   = r_obus;
        n_oaddr  = r_oaddr;
        n_oidx   = r_oidx;
        n_oval   = r_oval;
        n_olast  = r_olast;
        st_req   = '0;
        step1    = '0;
        step2    = '0;
        fin      = '0;
        case (r_ctl)
            ST_RUN: begin
                if (in_acc) begin
                    if (!r_ended) begin
                        if (c_in == 8'd0) begin
                            // nul ends the text of the line
                            n_ended = 1'b1;
                        end else begin
                            for (int i = 0; i < srcp_pkg::NUM_PAT; i++) begin
                                if (int'(r_pos) >= srcp_pkg::PAT_OFF[i] &&
                                    int'(r_pos) < srcp_pkg::PAT_OFF[i] + srcp_pkg::PAT_LEN[i]) begin
                                    if (u_in != srcp_pkg::pat_byte(i,
                                            6'(int'(r_pos) - srcp_pkg::PAT_OFF[i]))) begin
                                        n_pm[i] = 1'b0;
                                    end
                                end
                            end
                            case (r_on)
                                ON_WAIT: n_on = f_ws(c_in) ? ON_WAIT
                                              : ((u_in == "O") ? ON_O : ON_MISS);
                                ON_O:    n_on = (u_in == "N") ? ON_HIT : ON_MISS;
                                default: n_on = r_on;
                            endcase
                            // a number ended by this character is closed, then the
                            // character is scanned again in the new phase
                            step1 = f_scan(r_s, c_in);
                            if (!step1.cons) begin
                                step2    = f_scan(step1.s, c_in);
                                step1.s  = step2.s;
                                if (step2.we) begin
                                    step1.we = 1'b1;
                                    step1.wa = step2.wa;
                                    step1.wd = step2.wd;
                                end
                                step1.arm = step1.arm || step2.arm;
                            end
                            n_s       = step1.s;
                            st_req.we = step1.we;
                            st_req.wa = step1.wa;
                            st_req.wd = step1.wd;
                            if (step1.arm) n_on = ON_WAIT;
                            if (r_pos < 6'd63) n_pos = r_pos + 6'd1;
                        end
                    end
                    if (i_line.line_end) n_ctl = ST_FIN;
                end
            end
            ST_FIN: begin
                // close the open token, classify the line
                if (r_s.ph == PH_SKIP0 || r_s.ph == PH_DEV || r_s.ph == PH_SMDEV) begin
                    if (r_s.nf[NF_STARTED]) fin = f_end_word(r_s);
                    else fin.s = r_s;
                end else if (r_s.ph != PH_DONE && r_s.nf[NF_DIGIT]) begin
                    fin = f_end_number(r_s);
                end else begin
                    fin.s = r_s;
                end
                n_s       = fin.s;
                st_req.we = fin.we;
                st_req.wa = fin.wa;
                st_req.wd = fin.wd;
                if (f_matched(r_pm, r_pos, 0))      n_cmd = srcp_pkg::CMD_CONNMODE;
                else if (f_matched(r_pm, r_pos, 1)) n_cmd = srcp_pkg::CMD_PROTOCOL;
                else if (f_matched(r_pm, r_pos, 2)) n_cmd = srcp_pkg::CMD_SET;
                else if (f_matched(r_pm, r_pos, 3)) n_cmd = srcp_pkg::CMD_GET;
                else if (f_matched(r_pm, r_pos, 4)) n_cmd = srcp_pkg::CMD_WAIT;
                else if (f_matched(r_pm, r_pos, 5)) n_cmd = srcp_pkg::CMD_INIT;
                else if (f_matched(r_pm, r_pos, 6)) n_cmd = srcp_pkg::CMD_TERM;
                else if (f_matched(r_pm, r_pos, 7)) n_cmd = srcp_pkg::CMD_GO;
                else                                n_cmd = srcp_pkg::CMD_UNKNOWN;
                n_info = f_matched(r_pm, r_pos, srcp_pkg::PAT_INFO);
                n_ond  = (r_on == ON_HIT);
                n_k    = '0;
                n_pend = 1'b0;
                n_ctl  = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_pend) begin
                    // read data has landed, output register is free by construction
                    n_ovalid = 1'b1;
                    n_ocmd   = r_cmd;
                    n_odev   = setget ? r_s.dev : srcp_pkg::DEV_NONE;
                    n_obus   = setget ? r_s.bus : '0;
                    n_oaddr  = setget ? r_s.addr : '0;
                    n_oidx   = r_pk;
                    n_olast  = (r_pk == srcp_pkg::SLOT_W'(NUM_VALUES - 1));
                    n_oval   = '0;
                    case (r_cmd)
                        srcp_pkg::CMD_CONNMODE: begin
                            if (r_pk == '0) n_oval = {{(srcp_pkg::WORD_W-1){1'b0}}, r_info};
                        end
                        srcp_pkg::CMD_SET: begin
                            if (r_s.dev == srcp_pkg::DEV_POWER) begin
                                if (r_pk == '0) n_oval = {{(srcp_pkg::WORD_W-1){1'b0}}, r_ond};
                            end else if (r_s.dev == srcp_pkg::DEV_SM) begin
                                if (r_pk < 4'd3) n_oval = st_rd;
                            end else begin
                                n_oval = st_rd;
                            end
                        end
                        srcp_pkg::CMD_GET: begin
                            if (r_s.dev == srcp_pkg::DEV_SM && r_pk < 4'd2) n_oval = st_rd;
                        end
                        default: n_oval = '0;
                    endcase
                    n_pend = 1'b0;
                    if (r_pk == srcp_pkg::SLOT_W'(NUM_VALUES - 1)) begin
                        // line done: back to start-of-line state
                        n_s        = SCAN_INIT;
                        n_pos      = '0;
                        n_pm       = '1;
                        n_on       = ON_IDLE;
                        n_ended    = 1'b0;
                        n_cmd      = srcp_pkg::CMD_UNKNOWN;
                        n_ctl      = ST_RUN;
                        st_req.clr = 1'b1;
                    end
                end else if (r_k < srcp_pkg::SLOT_W'(NUM_VALUES) &&
                             (!r_ovalid || o_result.ready)) begin
                    st_req.re = 1'b1;
                    st_req.ra = r_k;
                    n_pk      = r_k;
                    n_k       = r_k + 4'd1;
                    n_pend    = 1'b1;
                end
            end
            default: n_ctl = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s      <= SCAN_INIT;
            r_pos    <= '0;
            r_pm     <= '1;
            r_on     <= ON_IDLE;
            r_ended  <= 1'b0;
            r_ctl    <= ST_RUN;
            r_cmd    <= srcp_pkg::CMD_UNKNOWN;
            r_info   <= 1'b0;
            r_ond    <= 1'b0;
            r_k      <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_s      <= n_s;
            r_pos    <= n_pos;
            r_pm     <= n_pm;
            r_on     <= n_on;
            r_ended  <= n_ended;
            r_ctl    <= n_ctl;
            r_cmd    <= n_cmd;
            r_info   <= n_info;
            r_ond    <= n_ond;
            r_k      <= n_k;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
        r_pk    <= n_pk;
        r_ocmd  <= n_ocmd;
        r_odev  <= n_odev;
        r_obus  <= n_obus;
        r_oaddr <= n_oaddr;
        r_oidx  <= n_oidx;
        r_oval  <= n_oval;
        r_olast <= n_olast;
    end

    srcp_value_store #(
        .NUM_VALUES (NUM_VALUES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (st_req),
        .o_rd    (st_rd)
    );

    assign i_line.ready          = (r_ctl == ST_RUN);
    assign o_result.valid        = r_ovalid;
    assign o_result.command_code = r_ocmd;
    assign o_result.device_code  = r_odev;
    assign o_result.bus_number   = r_obus;
    assign o_result.address      = r_oaddr;
    assign o_result.value_index  = r_oidx;
    assign o_result.value_word   = r_oval;
    assign o_result.last         = r_olast;

    // final character of a line closes the input for the next cycle
    a_line_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_line.line_end) |=> !i_line.ready)
        else $error("input still open after final character");

    // a pending store read always lands in the output register
    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> r_ovalid)
        else $error("store read data dropped");

    // value slot never runs past the store depth
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s.slot <= srcp_pkg::SLOT_W'(NUM_VALUES))
        else $error("value slot out of range");

endmodule
